FILE: hw/rtl/bipartite_check_and_max_matching_top_assert.svh
// Assertion macros for the bipartite matching block.
// Each expects clk and rst in scope where it is used.
`ifndef BIPARTITE_CHECK_AND_MAX_MATCHING_TOP_ASSERT_SVH
`define BIPARTITE_CHECK_AND_MAX_MATCHING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BCM_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("bcm check failed");
`define BCM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bcm check failed");
`else
`define BCM_ASSERT_IMPL(name, pre, post)
`define BCM_ASSERT_NEXT(name, pre, post)
`endif
`endif

FILE: hw/rtl/bcm_pkg.sv
`timescale 1ns / 1ps
package bcm_pkg;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_SOLVE = 1'b1;

  localparam logic [1:0] COL_NONE     = 2'd0;
  localparam logic [1:0] COL_FIRST    = 2'd1;
  localparam logic [1:0] COL_PAIR_SUM = 2'd3;

  localparam logic [8:0] VERTEX_COUNT_RESET = 9'd256;

  typedef struct packed {
    logic       req_type;
    logic [8:0] vertex_a;
    logic [8:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic       is_bipartite;
    logic [7:0] match_size;
  } out_word_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_ADD_RA,
    S_ADD_WA,
    S_ADD_RB,
    S_ADD_WB,
    S_C_START,
    S_C_SW,
    S_C_POP,
    S_C_POPW,
    S_C_ROWW,
    S_C_SCAN,
    S_C_CHK,
    S_M_START,
    S_M_LOAD,
    S_M_LOADW,
    S_M_SCAN,
    S_M_CHK,
    S_M_POP,
    S_M_UNW,
    S_M_UNWD,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/bcm_ram.sv
`timescale 1ns / 1ps
module bcm_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bipartite_check_and_max_matching_top.sv
`timescale 1ns / 1ps
// An edge word runs two row read-modify-writes; a solve word runs a colouring pass
// and, only if that finds the graph bipartite, a matching pass, both paced by the
// one-row-per-read adjacency memory and the single-step augmenting-path sequencer.
// One word at a time; input stalls from acceptance until back in idle.
// Reset (rst, synchronous): clears the adjacency, colour, parent and visited
// memories; the same clearing follows every solve. Configuration writes are always taken.
module bipartite_check_and_max_matching_top
  import bcm_pkg::*;
#(
  parameter int MAX_VERTICES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [8:0] cfg_data
);

`include "bipartite_check_and_max_matching_top_assert.svh"

  // IW indexes a vertex slot; VW holds a vertex number 1..N plus one past the end.
  localparam int N  = MAX_VERTICES;
  localparam int IW = $clog2(N);
  localparam int VW = $clog2(N + 2);
  localparam int CW = (VW > 10) ? VW : 10;
  localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

  state_t state, state_next;

  logic [8:0]    vertex_count;
  logic [VW-1:0] n, s, cu, cv, sp, sum;
  logic [VW-1:0] ea, eb;
  logic [1:0]    cucol;
  logic          bip;
  logic [IW-1:0] clr_idx;
  logic [N-1:0]  row;

  // Memory ports
  logic          adj_we, col_we, par_we, vis_we, stk_we;
  logic [IW-1:0] adj_wa, adj_ra, col_wa, col_ra, par_wa, par_ra;
  logic [IW-1:0] vis_wa, vis_ra, stk_wa, stk_ra;
  logic [N-1:0]  adj_wd, adj_rd;
  logic [1:0]    col_wd, col_rd;
  logic [VW-1:0] par_wd, par_rd, vis_wd, vis_rd;
  logic [2*VW-1:0] stk_wd, stk_rd;

  logic [IW-1:0] s_idx, cu_idx, cv_idx, ea_idx, eb_idx, sp_idx, sp_m1_idx, stk_v_idx;
  logic [VW-1:0] stk_u, stk_v;
  logic          in_acc;
  logic [CW-1:0] a_cw, b_cw, vc_cw, half_cw;
  logic          ends_ok;

  assign s_idx     = IW'(s - VW'(1));
  assign cu_idx    = IW'(cu - VW'(1));
  assign cv_idx    = IW'(cv - VW'(1));
  assign ea_idx    = IW'(ea - VW'(1));
  assign eb_idx    = IW'(eb - VW'(1));
  assign sp_idx    = IW'(sp);
  assign sp_m1_idx = IW'(sp - VW'(1));
  assign stk_u     = stk_rd[2*VW-1:VW];
  assign stk_v     = stk_rd[VW-1:0];
  assign stk_v_idx = IW'(stk_v - VW'(1));

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign a_cw    = CW'(in_data.vertex_a);
  assign b_cw    = CW'(in_data.vertex_b);
  assign vc_cw   = CW'(vertex_count);
  // Drop edges whose endpoints fall outside the vertex store.
  assign ends_ok = (a_cw >= CW'(1)) && (a_cw <= CW'(N)) &&
                   (b_cw >= CW'(1)) && (b_cw <= CW'(N));
  assign half_cw = CW'(sum) >> 1;

  bcm_ram #(.W(N), .D(N)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd)
  );
  bcm_ram #(.W(2), .D(N)) u_col (
    .clk(clk), .we(col_we), .waddr(col_wa), .wdata(col_wd), .raddr(col_ra), .rdata(col_rd)
  );
  bcm_ram #(.W(VW), .D(N)) u_par (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd)
  );
  // Visited marks hold the start vertex of the current search, so no per-start clear.
  bcm_ram #(.W(VW), .D(N)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
  );
  // Search stack: colouring keeps a vertex in the low half, matching a {u, v} frame.
  bcm_ram #(.W(2*VW), .D(N)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:     if (clr_idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == REQ_SOLVE) state_next = S_C_START;
          else if (ends_ok) state_next = S_ADD_RA;
        end
      end
      S_ADD_RA:  state_next = S_ADD_WA;
      S_ADD_WA:  state_next = S_ADD_RB;
      S_ADD_RB:  state_next = S_ADD_WB;
      S_ADD_WB:  state_next = S_IDLE;
      S_C_START: state_next = (s > n) ? S_M_START : S_C_SW;
      S_C_SW:    state_next = (col_rd == COL_NONE) ? S_C_POP : S_C_START;
      S_C_POP:   state_next = (sp == '0) ? S_C_START : S_C_POPW;
      S_C_POPW:  state_next = S_C_ROWW;
      S_C_ROWW:  state_next = S_C_SCAN;
      S_C_SCAN: begin
        if (cv > n) state_next = S_C_POP;
        else if (row[cv_idx]) state_next = S_C_CHK;
      end
      S_C_CHK: begin
        if (col_rd != COL_NONE && col_rd == cucol) state_next = S_DONE;
        else state_next = S_C_SCAN;
      end
      S_M_START: state_next = (s > n) ? S_DONE : S_M_LOAD;
      S_M_LOAD:  state_next = S_M_LOADW;
      S_M_LOADW: state_next = S_M_SCAN;
      S_M_SCAN: begin
        if (cv > n) state_next = (sp == '0) ? S_M_START : S_M_POP;
        else if (row[cv_idx]) state_next = S_M_CHK;
      end
      S_M_CHK: begin
        if (vis_rd == s) state_next = S_M_SCAN;
        else if (par_rd == '0) state_next = (sp == '0) ? S_M_START : S_M_UNW;
        else state_next = S_M_LOAD;
      end
      S_M_POP:   state_next = S_M_LOAD;
      S_M_UNW:   state_next = S_M_UNWD;
      S_M_UNWD:  state_next = (sp == '0) ? S_M_START : S_M_UNW;
      S_DONE:    if (!out_valid) state_next = S_CLR;
      default:   state_next = S_CLR;
    endcase
  end

  // Memory controls; every read port samples each cycle, data lands in the next state.
  always_comb begin
    adj_we = 1'b0; adj_wa = cu_idx; adj_wd = '0; adj_ra = cu_idx;
    col_we = 1'b0; col_wa = cv_idx; col_wd = COL_NONE; col_ra = cv_idx;
    par_we = 1'b0; par_wa = cv_idx; par_wd = cu; par_ra = cv_idx;
    vis_we = 1'b0; vis_wa = cv_idx; vis_wd = s; vis_ra = cv_idx;
    stk_we = 1'b0; stk_wa = sp_idx; stk_wd = {cu, cv}; stk_ra = sp_m1_idx;
    unique case (state)
      S_CLR: begin
        adj_we = 1'b1; adj_wa = clr_idx;
        col_we = 1'b1; col_wa = clr_idx;
        par_we = 1'b1; par_wa = clr_idx; par_wd = '0;
        vis_we = 1'b1; vis_wa = clr_idx; vis_wd = '0;
      end
      S_ADD_RA: adj_ra = ea_idx;
      S_ADD_WA: begin
        adj_we = 1'b1; adj_wa = ea_idx;
        adj_wd = adj_rd | (N'(1) << eb_idx);
      end
      S_ADD_RB: adj_ra = eb_idx;
      S_ADD_WB: begin
        adj_we = 1'b1; adj_wa = eb_idx;
        adj_wd = adj_rd | (N'(1) << ea_idx);
      end
      S_C_START: col_ra = s_idx;
      S_C_SW: begin
        if (col_rd == COL_NONE) begin
          col_we = 1'b1; col_wa = s_idx; col_wd = COL_FIRST;
          stk_we = 1'b1; stk_wa = '0; stk_wd = {VW'(0), s};
        end
      end
      S_C_POPW: begin
        adj_ra = stk_v_idx;
        col_ra = stk_v_idx;
      end
      S_C_CHK: begin
        if (col_rd == COL_NONE) begin
          col_we = 1'b1; col_wd = COL_PAIR_SUM - cucol;
          stk_we = 1'b1; stk_wd = {VW'(0), cv};
        end
      end
      S_M_CHK: begin
        if (vis_rd != s) begin
          vis_we = 1'b1;
          if (par_rd == '0) par_we = 1'b1;
          else stk_we = 1'b1;
        end
      end
      S_M_UNWD: begin
        par_we = 1'b1; par_wa = stk_v_idx; par_wd = stk_u;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      vertex_count <= VERTEX_COUNT_RESET;
      out_valid    <= 1'b0;
      sum          <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLR: clr_idx <= clr_idx + IW'(1);
        S_IDLE: begin
          // Latch the endpoints, or the effective vertex count for a solve.
          ea <= a_cw[VW-1:0];
          eb <= b_cw[VW-1:0];
          n  <= (vc_cw > CW'(N)) ? VW'(N) : vc_cw[VW-1:0];
          s  <= VW'(1);
          bip <= 1'b1;
        end
        S_C_START: begin
          if (s > n) begin
            s   <= VW'(1);
            sum <= '0;
          end
        end
        S_C_SW: begin
          if (col_rd == COL_NONE) sp <= VW'(1);
          else s <= s + VW'(1);
        end
        S_C_POP: begin
          if (sp == '0) s <= s + VW'(1);
          else sp <= sp - VW'(1);
        end
        S_C_POPW: cu <= stk_v;
        S_C_ROWW: begin
          row   <= adj_rd;
          cucol <= col_rd;
          cv    <= VW'(1);
        end
        S_C_SCAN: if (cv <= n && !row[cv_idx]) cv <= cv + VW'(1);
        S_C_CHK: begin
          if (col_rd == COL_NONE) begin
            sp <= sp + VW'(1);
            cv <= cv + VW'(1);
          end else if (col_rd == cucol) begin
            bip <= 1'b0;
          end else begin
            cv <= cv + VW'(1);
          end
        end
        S_M_START: begin
          cu <= s;
          cv <= VW'(1);
          sp <= '0;
        end
        S_M_LOADW: row <= adj_rd;
        S_M_SCAN: begin
          if (cv > n) begin
            if (sp == '0) s <= s + VW'(1);
            else sp <= sp - VW'(1);
          end else if (!row[cv_idx]) begin
            cv <= cv + VW'(1);
          end
        end
        S_M_CHK: begin
          if (vis_rd == s) begin
            cv <= cv + VW'(1);
          end else if (par_rd == '0) begin
            if (sp == '0) begin
              sum <= sum + VW'(1);
              s   <= s + VW'(1);
            end
          end else begin
            // Descend into the current partner of cv.
            sp <= sp + VW'(1);
            cu <= par_rd;
            cv <= VW'(1);
          end
        end
        S_M_POP: begin
          cu <= stk_u;
          cv <= stk_v + VW'(1);
        end
        S_M_UNW: sp <= sp - VW'(1);
        S_M_UNWD: begin
          if (sp == '0) begin
            sum <= sum + VW'(1);
            s   <= s + VW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid              <= 1'b1;
            out_data.is_bipartite  <= bip;
            out_data.match_size    <= !bip ? 8'd0 :
                                      (half_cw > CW'(255)) ? 8'hFF : half_cw[7:0];
            clr_idx                <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `BCM_ASSERT_IMPL(a_push_depth, state == S_M_CHK && vis_rd != s && par_rd != '0, sp < n)
  `BCM_ASSERT_NEXT(a_done_loads, state == S_DONE && !out_valid, out_valid)
  `BCM_ASSERT_IMPL(a_odd_zero, out_valid && !out_data.is_bipartite, out_data.match_size == 8'd0)
  `BCM_ASSERT_NEXT(a_solve_start, in_acc && in_data.req_type == REQ_SOLVE, state == S_C_START)

endmodule
